// ===== hdl/lid_pkg.sv =====
package lid_pkg;

	// Width of the whole-sample part of the delay register
	localparam int DELAY_WHOLE_BITS = 11;
	localparam logic [DELAY_WHOLE_BITS-1:0] DELAY_WHOLE_RESET = 11'd1024;

	// Width of the configuration register index
	localparam int CFG_INDEX_BITS = 4;

	// Configuration register map
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DELAY_WHOLE    = 4'd0,
		REG_DELAY_FRACTION = 4'd1
	} cfg_reg_t;

endpackage

// ===== hdl/lid_if.sv =====
// Input sample channel
interface lid_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// Output sample channel
interface lid_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// Register write channel
interface lid_cfg_if import lid_pkg::*; #(
	parameter int DATA_BITS = 16
);
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [DATA_BITS-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/linear_interp_delay_line.sv =====
// Linearly interpolating fractional delay line.
//
// Channels: "samples" takes one input word per handshake, "delayed" gives one
// output word for every input word, in order. "cfg" writes the delay
// registers: index 0 is the whole part D (saturated at LENGTH-1, which also
// forces the fraction to zero), index 1 the fraction f. cfg is always ready;
// write it only while no sample is in flight.
// Each output is ((1-f) * x[n-D] + f * x[n-D-1]), floored to the sample grid.
//
// Throughput: one word per cycle unless delayed stalls. Each word does one store
// write and two store reads in the cycle it is accepted; the store has one write
// and two read ports. A word passes the store read, product and output registers
// in turn (store read, multiply, blend into the output register).
// Stalls: up to three words sit in the pipeline; when delayed.ready is low the
// output register holds and the earlier stages keep filling until full, then
// samples.ready drops.
// Reset: the write position and all valid flags clear at once. The store reads
// as zero until each entry is first written, tracked by a wrap flag, so there
// is no clearing pass. The delay resets to 1024 whole samples, fraction zero.
module linear_interp_delay_line import lid_pkg::*; #(
	parameter int LENGTH        = 2048,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lid_in_if.sink     samples,
	lid_out_if.source  delayed,
	lid_cfg_if.sink    cfg
);

	localparam int AW = (LENGTH > 1) ? $clog2(LENGTH) : 1;
	localparam int CW = ((AW > DELAY_WHOLE_BITS) ? AW : DELAY_WHOLE_BITS) + 1;
	localparam int PW = SAMPLE_BITS + FRACTION_BITS + 2;
	localparam logic [AW:0]   LEN_EXT   = (AW+1)'(LENGTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(LENGTH - 1);
	localparam logic [CW-1:0] LAST_WIDE = CW'(LENGTH - 1);

	// Configuration
	logic [DELAY_WHOLE_BITS-1:0] delay_whole_q;
	logic [FRACTION_BITS-1:0]    delay_fraction_q;

	// Write side state
	logic [AW-1:0] wp_q;
	logic          fill_q;

	// Pipeline control
	logic v1_q, v2_q, out_valid_q;
	logic adv_out, ready_s2, ready_s1, accept;

	// Read address generation
	logic                     sat;
	logic [AW-1:0]            dsat;
	logic [FRACTION_BITS-1:0] frac_eff;
	logic [AW:0]              diff;
	logic [AW-1:0]            rd0_addr, rd1_addr;

	// Sample store and stage 1
	logic signed [SAMPLE_BITS-1:0] store [LENGTH];
	logic signed [SAMPLE_BITS-1:0] rd0_s1, rd1_s1, sample_s1;
	logic [FRACTION_BITS-1:0]      frac_s1;
	logic                          fwd0_s1, fwd1_s1, ok0_s1, ok1_s1;

	// Stage 1 arithmetic
	logic signed [SAMPLE_BITS-1:0] a, b;
	logic signed [SAMPLE_BITS:0]   span;
	logic signed [FRACTION_BITS:0] fs;
	logic signed [PW-1:0]          prod;

	// Stage 2 and output
	logic signed [PW-1:0]          prod_s2;
	logic signed [SAMPLE_BITS-1:0] base_s2;
	logic signed [PW-1:0]          sum;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	// Register writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q    <= DELAY_WHOLE_RESET;
			delay_fraction_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DELAY_WHOLE:    delay_whole_q    <= cfg.data[DELAY_WHOLE_BITS-1:0];
				REG_DELAY_FRACTION: delay_fraction_q <= cfg.data[FRACTION_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: each stage advances when the next one is free or moving
	assign adv_out       = !out_valid_q || delayed.ready;
	assign ready_s2      = !v2_q || adv_out;
	assign ready_s1      = !v1_q || ready_s2;
	assign samples.ready = ready_s1;
	assign accept        = samples.valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) v1_q <= samples.valid;
			if (ready_s2) v2_q <= v1_q;
			if (adv_out) out_valid_q <= v2_q;
		end
	end

	// Advance the write position; mark the store full after the first wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= 1'b0;
		end else if (accept) begin
			wp_q   <= (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
			fill_q <= fill_q || (wp_q == LAST_ADDR);
		end
	end

	// Saturate the delay and form the two tap addresses
	always_comb begin
		sat      = CW'(delay_whole_q) >= LAST_WIDE;
		dsat     = sat ? LAST_ADDR : AW'(delay_whole_q);
		frac_eff = sat ? '0 : delay_fraction_q;
		diff     = {1'b0, wp_q} - {1'b0, dsat};
		rd0_addr = diff[AW] ? AW'(diff + LEN_EXT) : diff[AW-1:0];
		rd1_addr = (rd0_addr == '0) ? LAST_ADDR : rd0_addr - 1'b1;
	end

	// Store: write the new word, read both taps
	always_ff @(posedge clk) begin
		if (accept) begin
			store[wp_q] <= samples.sample_in;
			rd0_s1      <= store[rd0_addr];
			rd1_s1      <= store[rd1_addr];
		end
	end

	// Carry forwarding and written-yet flags with the read
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample_in;
			frac_s1   <= frac_eff;
			fwd0_s1   <= rd0_addr == wp_q;
			fwd1_s1   <= rd1_addr == wp_q;
			ok0_s1    <= fill_q || (rd0_addr < wp_q);
			ok1_s1    <= fill_q || (rd1_addr < wp_q);
		end
	end

	// Pick tap values and multiply the fraction by their difference
	always_comb begin
		a    = fwd0_s1 ? sample_s1 : (ok0_s1 ? rd0_s1 : '0);
		b    = fwd1_s1 ? sample_s1 : (ok1_s1 ? rd1_s1 : '0);
		span = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
		fs   = {1'b0, frac_s1};
		prod = span * fs;
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			prod_s2 <= prod;
			base_s2 <= a;
		end
	end

	// Blend: a + floor(f * (b - a) / 2^FRACTION_BITS)
	assign sum = (prod_s2 >>> FRACTION_BITS) + PW'(base_s2);

	always_ff @(posedge clk) begin
		if (adv_out) sample_out_q <= sum[SAMPLE_BITS-1:0];
	end

	assign delayed.valid      = out_valid_q;
	assign delayed.sample_out = sample_out_q;

endmodule

// ===== hdl/lid_checker.sv =====
module lid_props #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	logic [2:0] cnt_q;
	logic       in_take, out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Track words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_take) - 3'(out_take);
		end
	end

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write not taken at once");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("stalled output word changed or dropped");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 3'd0)
		else $error("output word with no input word outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd3)
		else $error("more words in flight than pipeline stages");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");

endmodule

bind linear_interp_delay_line lid_props #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_lid_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (delayed.valid),
	.out_ready  (delayed.ready),
	.sample_out (delayed.sample_out),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready)
);
